// ===== rtl/core/rsrt_pkg.sv =====
// ============================================================================
// Request slot retransmit tracker package
// Widths, codes and reset values shared by the tracker.
// ============================================================================
package rsrt_pkg;

   localparam int SLOTS    = 16;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int TAG_W    = 24;
   localparam int TIME_W   = 32;
   localparam int WAIT_W   = 16;
   localparam int CNT_W    = 16;
   localparam int OUTS_W   = 5;
   localparam int RETRY_W  = 4;
   localparam int BACKOFF_W = 11;

   localparam logic [1:0] ACT_SUBMIT   = 2'd0;
   localparam logic [1:0] ACT_RESPONSE = 2'd1;
   localparam logic [1:0] ACT_TICK     = 2'd2;

   localparam logic [2:0] KIND_SEND    = 3'd0;
   localparam logic [2:0] KIND_FULL    = 3'd1;
   localparam logic [2:0] KIND_DONE    = 3'd2;
   localparam logic [2:0] KIND_IGNORED = 3'd3;
   localparam logic [2:0] KIND_RESEND  = 3'd4;
   localparam logic [2:0] KIND_FAILED  = 3'd5;

   localparam logic CSR_BACKOFF = 1'b0;
   localparam logic CSR_LIMIT   = 1'b1;

   localparam logic [BACKOFF_W-1:0] BACKOFF_RESET = 11'd100;
   localparam logic [RETRY_W-1:0]   LIMIT_RESET   = 4'd10;

   typedef struct packed {
      logic [2:0]        kind;
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0]  tag;
      logic [OUTS_W-1:0] outstanding;
   } result_type;

endpackage

// ===== rtl/core/request_slot_retransmit_tracker_top.sv =====
// ============================================================================
// Request slot retransmit tracker
// Submit takes the lowest free slot, a response frees a matching slot, and a
// tick checks every slot in turn, resending or failing expired requests.
// A submit examines one slot a cycle, starting at slot 0, until it finds a
// free slot or reaches the last one.
// One transfer at a time; the shared 32-bit adder that tests and
// sets deadlines is used once a cycle under the sequencer.
// Reset clears the busy bits, counters, time and the response valid flag and
// restores the register defaults; the slot payload tables are not cleared.
// ============================================================================
module request_slot_retransmit_tracker_top
   import rsrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // first_wait[15:0], resp_tag[39:16]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // slot[3:0], tag[27:4], outstanding[32:28], zeros
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SUBMIT, ST_RESP, ST_TEST, ST_UPDATE, ST_FLUSH
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   state_type                 state_ff;
   logic [SLOTS-1:0]          busy_ff;
   logic [TAG_W-1:0]          tag_ff      [SLOTS];
   logic [TIME_W-1:0]         deadline_ff [SLOTS];
   logic [RETRY_W-1:0]        retries_ff  [SLOTS];
   logic [CNT_W-1:0]          counter_ff;
   logic [OUTS_W-1:0]         count_ff;
   logic [TIME_W-1:0]         time_ff;
   logic [BACKOFF_W-1:0]      backoff_ff;
   logic [RETRY_W-1:0]        limit_ff;
   logic [SLOT_W-1:0]         idx_ff;
   logic [WAIT_W-1:0]         wait_ff;
   logic [TAG_W-1:0]          rtag_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_last_ff;
   result_type                rsp_ff;
   logic                      pend_valid_ff;
   result_type                pend_ff;

   logic                      out_free;
   logic [TIME_W-1:0]         alu_b;
   logic                      alu_sub;
   logic [TIME_W-1:0]         alu_sum;
   logic [TIME_W-1:0]         backoff_shifted;
   logic [RETRY_W-1:0]        old_retries;
   logic [RETRY_W:0]          new_retries;
   logic                      fail;
   logic                      hit;
   logic                      resp_match;
   logic [TAG_W-1:0]          new_tag;

   assign out_free        = !rsp_valid_ff || rsp_tready;
   assign old_retries     = retries_ff[idx_ff];
   assign new_retries     = {1'b0, old_retries} + (RETRY_W+1)'(1);
   assign fail            = new_retries >= {1'b0, limit_ff};
   assign backoff_shifted = TIME_W'(backoff_ff) << old_retries;
   assign new_tag         = {counter_ff, {(8-SLOT_W){1'b0}}, idx_ff};
   assign resp_match      = (rtag_ff[7:SLOT_W] == '0) && busy_ff[idx_ff]
                            && (tag_ff[idx_ff] == rtag_ff);

   always_comb begin
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         ST_SUBMIT: begin
            alu_b = TIME_W'(wait_ff);
         end
         ST_TEST: begin
            alu_b   = deadline_ff[idx_ff];
            alu_sub = 1'b1;
         end
         ST_UPDATE: begin
            alu_b = backoff_shifted;
         end
         default: begin
            alu_b = '0;
         end
      endcase
      alu_sum = time_ff + (alu_sub ? ~alu_b : alu_b) + TIME_W'(alu_sub);
   end

   assign hit = busy_ff[idx_ff] && !alu_sum[TIME_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= '0;
         counter_ff    <= '0;
         count_ff      <= '0;
         time_ff       <= '0;
         backoff_ff    <= BACKOFF_RESET;
         limit_ff      <= LIMIT_RESET;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            if (csr_index == CSR_BACKOFF) begin
               backoff_ff <= csr_wdata;
            end else begin
               limit_ff <= csr_wdata[RETRY_W-1:0];
            end
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  wait_ff <= req_tdata[15:0];
                  rtag_ff <= req_tdata[39:16];
                  case (req_tuser)
                     ACT_SUBMIT: begin
                        idx_ff   <= '0;
                        state_ff <= ST_SUBMIT;
                     end
                     ACT_RESPONSE: begin
                        idx_ff   <= req_tdata[16 +: SLOT_W];
                        state_ff <= ST_RESP;
                     end
                     ACT_TICK: begin
                        idx_ff   <= '0;
                        time_ff  <= time_ff + TIME_W'(1);
                        state_ff <= ST_TEST;
                     end
                     default: begin
                        idx_ff   <= '0;
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_SUBMIT: begin
               if (!busy_ff[idx_ff] || idx_ff == LAST_SLOT) begin
                  if (out_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_last_ff  <= 1'b1;
                     state_ff     <= ST_IDLE;
                     if (!busy_ff[idx_ff]) begin
                        busy_ff[idx_ff]     <= 1'b1;
                        tag_ff[idx_ff]      <= new_tag;
                        deadline_ff[idx_ff] <= alu_sum;
                        retries_ff[idx_ff]  <= '0;
                        counter_ff          <= counter_ff + CNT_W'(1);
                        count_ff            <= count_ff + OUTS_W'(1);
                        rsp_ff <= '{kind: KIND_SEND, slot: idx_ff, tag: new_tag,
                                    outstanding: count_ff + OUTS_W'(1)};
                     end else begin
                        rsp_ff <= '{kind: KIND_FULL, slot: '0, tag: '0,
                                    outstanding: count_ff};
                     end
                  end
               end else begin
                  idx_ff <= idx_ff + SLOT_W'(1);
               end
            end
            ST_RESP: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= ST_IDLE;
                  if (resp_match) begin
                     busy_ff[idx_ff] <= 1'b0;
                     count_ff        <= count_ff - OUTS_W'(1);
                     rsp_ff <= '{kind: KIND_DONE, slot: idx_ff, tag: rtag_ff,
                                 outstanding: count_ff - OUTS_W'(1)};
                  end else begin
                     rsp_ff <= '{kind: KIND_IGNORED, slot: rtag_ff[SLOT_W-1:0],
                                 tag: rtag_ff, outstanding: count_ff};
                  end
               end
            end
            ST_TEST: begin
               if (hit) begin
                  state_ff <= ST_UPDATE;
               end else if (idx_ff == LAST_SLOT) begin
                  state_ff <= ST_FLUSH;
               end else begin
                  idx_ff <= idx_ff + SLOT_W'(1);
               end
            end
            ST_UPDATE: begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_ff       <= pend_ff;
                     rsp_last_ff  <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                  end
                  pend_valid_ff       <= 1'b1;
                  deadline_ff[idx_ff] <= alu_sum;
                  retries_ff[idx_ff]  <= new_retries[RETRY_W-1:0];
                  if (fail) begin
                     busy_ff[idx_ff] <= 1'b0;
                     count_ff        <= count_ff - OUTS_W'(1);
                     pend_ff <= '{kind: KIND_FAILED, slot: idx_ff, tag: tag_ff[idx_ff],
                                  outstanding: count_ff - OUTS_W'(1)};
                  end else begin
                     pend_ff <= '{kind: KIND_RESEND, slot: idx_ff, tag: tag_ff[idx_ff],
                                  outstanding: count_ff};
                  end
                  if (idx_ff == LAST_SLOT) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     idx_ff   <= idx_ff + SLOT_W'(1);
                     state_ff <= ST_TEST;
                  end
               end
            end
            ST_FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_ff        <= pend_ff;
                  rsp_last_ff   <= 1'b1;
                  rsp_valid_ff  <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {7'b0, rsp_ff.outstanding, rsp_ff.tag, rsp_ff.slot};

`ifndef SYNTHESIS
   a_count_matches_busy: assert property (@(posedge clock) disable iff (reset)
      count_ff == OUTS_W'($countones(busy_ff)))
      else $error("Outstanding count differs from the number of busy slots.");

   a_pending_only_in_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_TEST || state_ff == ST_UPDATE
                         || state_ff == ST_FLUSH))
      else $error("A held tick result survived the end of its tick.");

   a_send_marks_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUBMIT && out_free && !busy_ff[idx_ff])
      |=> (rsp_valid_ff && rsp_ff.kind == KIND_SEND && busy_ff[rsp_ff.slot]))
      else $error("A send transfer does not refer to a newly occupied slot.");
`endif

endmodule
